// ===== rtl/keyed_record_table_defines.svh =====
// Assertion macros shared by the keyed record table RTL.
// Included by files that carry concurrent assertions; expects aclk and aresetn in scope.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define KRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/krt_pkg.sv =====
// Package for the keyed record table: sizes, request and status codes,
// record and result types. No dependencies.
package krt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OCC_W       = 6;
    localparam int KEY_W       = 32;
    localparam int LABEL_W     = 64;
    localparam int SCORE_W     = 10;
    localparam int S_DATA_W    = 112;
    localparam int M_DATA_W    = 112;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_LOOKUP,
        KIND_DELETE,
        KIND_DUMP
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_MISS,
        ST_EMPTY
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [LABEL_W-1:0] label;
        logic [KEY_W-1:0]   key;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        status_t          status;
        rec_t             rec;
        logic             last;
        logic [OCC_W-1:0] occ;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        rec_t             wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== rtl/krt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/krt_seq.sv =====
// Request sequencer for the keyed record table: walks the record RAM one entry per cycle
// (a dump waits on out_free) with a single key comparator and pointer incrementer. Uses krt_pkg.
module krt_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  krt_pkg::kind_t            in_kind,
    input  krt_pkg::rec_t             in_rec,
    input  logic                      out_free,
    output logic                      push,
    output krt_pkg::res_t             push_res,
    output krt_pkg::mem_req_t         mem_req,
    input  krt_pkg::rec_t             rd_rec,
    output logic [krt_pkg::CNT_W-1:0] count
);

    import krt_pkg::*;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    status_t            status_reg, status_next;
    rec_t               hold_reg, hold_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   ptr_dec;
    logic               last_idx;
    logic               hit;
    logic               is_full;
    logic               is_empty;

    // The read address always follows the next pointer, so the registered read
    // data holds the entry at ptr_reg during every scan, shift or dump cycle.
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign last_idx = (ptr_inc == count_reg);
    assign hit      = (rd_rec.key == key_reg);
    assign is_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign is_empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        hold_reg   <= hold_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (in_kind)
                        KIND_INSERT: state_next = S_RESP;
                        KIND_LOOKUP, KIND_DELETE: state_next = is_empty ? S_RESP : S_SCAN;
                        KIND_DUMP: state_next = is_empty ? S_RESP : S_DUMP;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = (kind_reg == KIND_DELETE) ? S_SHIFT : S_RESP;
                end else if (last_idx) begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT: begin
                if (ptr_reg == count_reg) begin
                    state_next = S_RESP;
                end
            end
            S_DUMP: begin
                if (out_free && last_idx) begin
                    state_next = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        in_ready      = 1'b0;
        kind_next     = kind_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        hold_next     = hold_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[IDX_W-1:0];
        mem_req.wdata = in_rec;
        push          = 1'b0;
        push_res.status = status_reg;
        push_res.rec    = hold_reg;
        push_res.last   = 1'b1;
        push_res.occ    = OCC_W'(count_reg);

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                ptr_next = '0;
                if (in_valid) begin
                    kind_next = in_kind;
                    key_next  = in_rec.key;
                    hold_next = '0;
                    case (in_kind)
                        KIND_INSERT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                status_next = ST_OK;
                                hold_next   = in_rec;
                                mem_req.we  = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        KIND_LOOKUP, KIND_DELETE: status_next = ST_MISS;
                        KIND_DUMP: status_next = ST_EMPTY;
                        default: status_next = ST_MISS;
                    endcase
                end
            end
            S_SCAN: begin
                ptr_next = ptr_inc;
                if (hit) begin
                    status_next = ST_OK;
                    hold_next   = rd_rec;
                end
            end
            S_SHIFT: begin
                if (ptr_reg == count_reg) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    // Move the entry at ptr_reg down one place.
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ptr_dec[IDX_W-1:0];
                    mem_req.wdata = rd_rec;
                    ptr_next      = ptr_inc;
                end
            end
            S_DUMP: begin
                push            = out_free;
                push_res.status = ST_OK;
                push_res.rec    = rd_rec;
                push_res.last   = last_idx;
                if (out_free) begin
                    ptr_next = ptr_inc;
                end
            end
            S_RESP: begin
                push = out_free;
            end
            default: begin
                ptr_next = '0;
            end
        endcase

        mem_req.raddr = ptr_next[IDX_W-1:0];
    end

    assign count = count_reg;

endmodule

// ===== rtl/krt_out.sv =====
// Result output register for the keyed record table: holds one result word
// and drives the master stream ports. Uses krt_pkg.
module krt_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  krt_pkg::res_t                push_res,
    output logic                         out_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [krt_pkg::M_DATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    import krt_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg, res_next;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (push) begin
            valid_next = 1'b1;
            res_next   = push_res;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_DATA_W'({res_reg.occ, res_reg.rec});
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;

endmodule

// ===== rtl/keyed_record_table.sv =====
// Keyed record table: an ordered table of up to 32 records (key, eight-byte
// label, score). Insert appends, lookup returns the first matching record,
// delete removes the first match and closes the gap, dump streams all records
// in order with tlast on the final word (one empty status word if none). One
// request is handled at a time; s_tready is high only while the sequencer is
// idle. The sequencer walks the single RAM read port one entry per cycle,
// waiting in a dump while the output is not free (delete reuses the port
// to move later records down). A result word may wait in the output
// register while the next request is taken. Depends on krt_pkg, krt_ram,
// krt_seq, krt_out and keyed_record_table_defines.svh.
`include "keyed_record_table_defines.svh"

module keyed_record_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [krt_pkg::S_DATA_W-1:0] s_tdata,  // key[31:0], label[95:32], score[105:96]
    input  logic [1:0]                   s_tuser,  // kind[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [krt_pkg::M_DATA_W-1:0] m_tdata,  // found_key[31:0], found_label[95:32],
                                                   // found_score[105:96], occupancy[111:106]
    output logic [1:0]                   m_tuser,  // status[1:0]
    output logic                         m_tlast
);

    import krt_pkg::*;

    kind_t            s_kind;
    rec_t             s_rec;
    logic             out_free;
    logic             push;
    res_t             push_res;
    mem_req_t         mem_req;
    rec_t             rd_rec;
    logic [CNT_W-1:0] count;

    assign s_kind = kind_t'(s_tuser);
    assign s_rec  = rec_t'(s_tdata[REC_W-1:0]);

    krt_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_kind),
        .in_rec   (s_rec),
        .out_free (out_free),
        .push     (push),
        .push_res (push_res),
        .mem_req  (mem_req),
        .rd_rec   (rd_rec),
        .count    (count)
    );

    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_rec)
    );

    krt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // An accepted insert into a table with room grows the count by one.
    `KRT_ASSERT_NEXT(a_insert_grows, s_tvalid && s_tready && s_kind == KIND_INSERT && count != CNT_W'(TABLE_DEPTH), count == $past(count) + 1'b1, "insert did not grow the table")

    // A full status is only reported with the table at capacity.
    `KRT_ASSERT_IMP(a_full_at_cap, m_tvalid && m_tuser == ST_FULL, m_tdata[111:106] == OCC_W'(TABLE_DEPTH) && m_tlast, "full status with room left")

    // An empty status is a single word and reports no records held.
    `KRT_ASSERT_IMP(a_empty_word, m_tvalid && m_tuser == ST_EMPTY, m_tdata[111:106] == '0 && m_tlast, "empty status with records held")

endmodule

// ===== sim/keyed_record_table_tb.sv =====
// Self-checking testbench for keyed_record_table: directed and random request streams,
// each result word compared against a directed expectation or an in-bench table model.
// Depends on krt_pkg and the keyed_record_table RTL.
module keyed_record_table_tb;
    import krt_pkg::*;

    typedef struct packed {
        status_t      status;
        logic [31:0]  key;
        logic [63:0]  label;
        logic [9:0]   score;
        logic [5:0]   occ;
        logic         last;
    } table_word_t;

    typedef struct packed {
        logic         typed;
        kind_t        kind;
        logic [31:0]  key;
        logic [63:0]  label;
        logic [9:0]   score;
        table_word_t  want;
    } plan_row_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;   // key[31:0], label[95:32], score[105:96]
    logic [1:0]   s_tuser  = '0;   // kind[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;         // found_key[31:0], found_label[95:32],
                                   // found_score[105:96], occupancy[111:106]
    logic [1:0]   m_tuser;         // status[1:0]
    logic         m_tlast;

    keyed_record_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the table contents.
    logic [31:0]  shadow_key   [TABLE_DEPTH];
    logic [63:0]  shadow_label [TABLE_DEPTH];
    logic [9:0]   shadow_score [TABLE_DEPTH];
    int           shadow_count = 0;

    table_word_t  fresh_words [$];
    table_word_t  awaited_words [$];
    plan_row_t    plan [22];

    int  errors = 0;
    int  words_checked = 0;
    int  requests_sent = 0;
    int  full_rejects = 0;
    bit  no_idle = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic table_word_t make_word(status_t st, logic [31:0] key,
                                              logic [63:0] label, logic [9:0] score,
                                              logic last);
        table_word_t w;
        w.status = st;
        w.key    = key;
        w.label  = label;
        w.score  = score;
        w.occ    = shadow_count[5:0];
        w.last   = last;
        return w;
    endfunction

    // Updates the shadow table for one request and queues the words it should produce.
    function automatic void apply_request(kind_t kind, logic [31:0] key,
                                          logic [63:0] label, logic [9:0] score);
        int hit;
        logic [31:0] hk;
        logic [63:0] hl;
        logic [9:0]  hs;
        hit = -1;
        case (kind)
            KIND_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    full_rejects++;
                    fresh_words.push_back(make_word(ST_FULL, '0, '0, '0, 1'b1));
                end else begin
                    shadow_key[shadow_count]   = key;
                    shadow_label[shadow_count] = label;
                    shadow_score[shadow_count] = score;
                    shadow_count++;
                    fresh_words.push_back(make_word(ST_OK, key, label, score, 1'b1));
                end
            end
            KIND_LOOKUP, KIND_DELETE: begin
                for (int i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_key[i] == key)
                        hit = i;
                if (hit < 0) begin
                    fresh_words.push_back(make_word(ST_MISS, '0, '0, '0, 1'b1));
                end else begin
                    hk = shadow_key[hit];
                    hl = shadow_label[hit];
                    hs = shadow_score[hit];
                    if (kind == KIND_DELETE) begin
                        // Later records move down one place to close the gap.
                        for (int i = hit; i + 1 < shadow_count; i++) begin
                            shadow_key[i]   = shadow_key[i+1];
                            shadow_label[i] = shadow_label[i+1];
                            shadow_score[i] = shadow_score[i+1];
                        end
                        shadow_count--;
                    end
                    fresh_words.push_back(make_word(ST_OK, hk, hl, hs, 1'b1));
                end
            end
            default: begin
                if (shadow_count == 0)
                    fresh_words.push_back(make_word(ST_EMPTY, '0, '0, '0, 1'b1));
                else
                    for (int i = 0; i < shadow_count; i++)
                        fresh_words.push_back(make_word(ST_OK, shadow_key[i],
                            shadow_label[i], shadow_score[i], i == shadow_count - 1));
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_request(kind_t kind, logic [31:0] key, logic [63:0] label,
                                logic [9:0] score);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, score, label, key};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        apply_request(kind, key, label, score);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pool_key();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0007;
            default: return 32'h1234_5678;
        endcase
    endfunction

    // Weights are percentages for insert, lookup and delete; the rest are dumps.
    task automatic random_item(int w_ins, int w_look, int w_del);
        int r;
        int k;
        kind_t kind;
        logic [31:0] key;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            kind = KIND_INSERT;
        else if (r < w_ins + w_look)
            kind = KIND_LOOKUP;
        else if (r < w_ins + w_look + w_del)
            kind = KIND_DELETE;
        else
            kind = KIND_DUMP;
        k = $urandom_range(0, 99);
        if (kind == KIND_INSERT)
            key = (k < 35) ? pool_key() : $urandom;
        else if (k < 70 && shadow_count > 0)
            key = shadow_key[$urandom_range(0, shadow_count - 1)];
        else
            key = (k < 85) ? pool_key() : $urandom;
        send_request(kind, key, {$urandom, $urandom}, 10'($urandom_range(0, 1023)));
        awaited_words = {awaited_words, fresh_words};
        fresh_words.delete();
    endtask

    // Output side stalls: mostly short, now and then long.
    always @(posedge aclk) begin : ready_gen
        int left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            left = 0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else if (left > 0) begin
            left--;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                 : $urandom_range(15, 50);
        end else begin
            m_tready <= 1'b1;
            left = $urandom_range(0, 25);
        end
    end

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : word_check
        table_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h/%h/%b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                w = awaited_words.pop_front();
                words_checked++;
                check_field("status", w.status, m_tuser);
                check_field("found_key", w.key, m_tdata[31:0]);
                check_field("found_label", w.label, m_tdata[95:32]);
                check_field("found_score", w.score, m_tdata[105:96]);
                check_field("occupancy", w.occ, m_tdata[111:106]);
                check_field("last", w.last, m_tlast);
            end
        end
    end

    initial begin
        int guard;
        plan = '{
            '{1'b1, KIND_DUMP,   32'h0,         64'h0,                 10'h0,
              '{ST_EMPTY, 32'h0, 64'h0, 10'h0, 6'd0, 1'b1}},
            '{1'b1, KIND_LOOKUP, 32'h5,         64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF,
              '{ST_MISS, 32'h0, 64'h0, 10'h0, 6'd0, 1'b1}},
            '{1'b1, KIND_DELETE, 32'hFFFF_FFFF, 64'h0,                 10'h0,
              '{ST_MISS, 32'h0, 64'h0, 10'h0, 6'd0, 1'b1}},
            '{1'b1, KIND_INSERT, 32'h0,         64'h0,                 10'h0,
              '{ST_OK, 32'h0, 64'h0, 10'h0, 6'd1, 1'b1}},
            '{1'b1, KIND_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF,
              '{ST_OK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 6'd2, 1'b1}},
            '{1'b1, KIND_INSERT, 32'h1234_5678, 64'h5245_434F_5244_5F41, 10'h200,
              '{ST_OK, 32'h1234_5678, 64'h5245_434F_5244_5F41, 10'h200, 6'd3, 1'b1}},
            '{1'b1, KIND_INSERT, 32'h0,         64'h4455_504C_4943_4154, 10'h001,
              '{ST_OK, 32'h0, 64'h4455_504C_4943_4154, 10'h001, 6'd4, 1'b1}},
            '{1'b0, KIND_LOOKUP, 32'h0,         64'h0, 10'h0, '0},
            '{1'b0, KIND_LOOKUP, 32'hFFFF_FFFF, 64'h0, 10'h0, '0},
            '{1'b1, KIND_LOOKUP, 32'h1234_5679, 64'h0,                 10'h0,
              '{ST_MISS, 32'h0, 64'h0, 10'h0, 6'd4, 1'b1}},
            '{1'b0, KIND_DUMP,   32'h0,         64'h0, 10'h0, '0},
            '{1'b0, KIND_DELETE, 32'h0,         64'h0, 10'h0, '0},
            '{1'b0, KIND_LOOKUP, 32'h0,         64'h0, 10'h0, '0},
            '{1'b0, KIND_DELETE, 32'h1234_5678, 64'h0, 10'h0, '0},
            '{1'b0, KIND_DUMP,   32'h0,         64'h0, 10'h0, '0},
            '{1'b0, KIND_DELETE, 32'hFFFF_FFFF, 64'h0, 10'h0, '0},
            '{1'b0, KIND_DELETE, 32'h0,         64'h0, 10'h0, '0},
            '{1'b1, KIND_DELETE, 32'h0,         64'h0,                 10'h0,
              '{ST_MISS, 32'h0, 64'h0, 10'h0, 6'd0, 1'b1}},
            '{1'b1, KIND_DUMP,   32'h0,         64'h0,                 10'h0,
              '{ST_EMPTY, 32'h0, 64'h0, 10'h0, 6'd0, 1'b1}},
            '{1'b1, KIND_INSERT, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 10'h2AA,
              '{ST_OK, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 10'h2AA, 6'd1, 1'b1}},
            '{1'b1, KIND_INSERT, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 10'h155,
              '{ST_OK, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 10'h155, 6'd2, 1'b1}},
            '{1'b0, KIND_DUMP,   32'h0,         64'h0, 10'h0, '0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: typed expectations replace the shadow model's words.
        foreach (plan[i]) begin
            send_request(plan[i].kind, plan[i].key, plan[i].label, plan[i].score);
            if (plan[i].typed)
                awaited_words.push_back(plan[i].want);
            else
                awaited_words = {awaited_words, fresh_words};
            fresh_words.delete();
        end
        wait_drain();

        // Fill the table, then push against the full limit.
        guard = 0;
        while (shadow_count < TABLE_DEPTH && guard < 80) begin
            random_item(90, 5, 0);
            guard++;
        end
        repeat (3) random_item(100, 0, 0);
        random_item(0, 0, 0);
        wait_drain();

        // Drain mostly by deletes, with neither side idling.
        no_idle = 1'b1;
        guard = 0;
        while (shadow_count > 0 && guard < 70) begin
            random_item(0, 10, 90);
            guard++;
        end
        random_item(0, 0, 0);
        wait_drain();
        no_idle = 1'b0;

        repeat (12) random_item(40, 25, 25);

        wait_drain();
        repeat (40) @(posedge aclk);
        $display("Sent %0d requests (%0d directed) and checked %0d result words;",
                 requests_sent, $size(plan), words_checked);
        $display("the table was filled and drained, with %0d inserts rejected as full.",
                 full_rejects);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #8000000;
        $display("Timeout with %0d result words still awaited.", awaited_words.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
